[src/cmd_pkg.sv]
package cmd_pkg;

  // message length counter width
  localparam int unsigned LENGTH_BITS = 24;
  localparam int unsigned CHUNK_BITS  = 16;
  localparam int unsigned MSG_LEN_W   = 24;
  localparam int unsigned OUT_DATA_W  = 40;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOM  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LINK = 2'd1,
    ERR_BIG  = 2'd2
  } err_code_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             data_byte;
    logic [MSG_LEN_W-1:0]   message_length;
    err_code_t              error_code;
  } result_t;

endpackage

[src/cmd_core.sv]
module cmd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  logic            link_fault,
  output logic            res_valid,
  output cmd_pkg::result_t res
);
  import cmd_pkg::*;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  phase_t                  phase, phase_next;
  logic [7:0]              header_high, header_high_next;
  logic [CHUNK_BITS-1:0]   bytes_left, bytes_left_next;
  logic [LENGTH_BITS-1:0]  length_so_far, length_so_far_next;
  err_code_t               sticky_error, sticky_error_next;

  logic [CHUNK_BITS-1:0]   chunk;
  logic [LENGTH_BITS:0]    len_sum;

  assign chunk   = {header_high, rx_byte};
  // carry out of the sum means the bound is passed
  assign len_sum = {1'b0, length_so_far} + (LENGTH_BITS + 1)'(chunk);

  always_comb begin
    phase_next         = phase;
    header_high_next   = header_high;
    bytes_left_next    = bytes_left;
    length_so_far_next = length_so_far;
    sticky_error_next  = sticky_error;
    res_valid          = 1'b0;
    res                = '0;
    res.kind           = KIND_DATA;
    res.error_code     = ERR_NONE;
    if (sticky_error != ERR_NONE) begin
      res_valid      = 1'b1;
      res.kind       = KIND_ERR;
      res.error_code = sticky_error;
    end else if (link_fault) begin
      sticky_error_next = ERR_LINK;
      res_valid         = 1'b1;
      res.kind          = KIND_ERR;
      res.error_code    = ERR_LINK;
    end else begin
      case (phase)
        PH_LOW: begin
          if (chunk == '0) begin
            length_so_far_next = '0;
            phase_next         = PH_HIGH;
            res_valid          = 1'b1;
            res.kind           = KIND_EOM;
            res.message_length = MSG_LEN_W'(length_so_far);
          end else if (len_sum[LENGTH_BITS]) begin
            sticky_error_next = ERR_BIG;
            res_valid         = 1'b1;
            res.kind          = KIND_ERR;
            res.error_code    = ERR_BIG;
          end else begin
            bytes_left_next = chunk;
            phase_next      = PH_PAY;
          end
        end
        PH_PAY: begin
          length_so_far_next = length_so_far + LENGTH_BITS'(1);
          bytes_left_next    = bytes_left - CHUNK_BITS'(1);
          if (bytes_left == CHUNK_BITS'(1)) begin
            phase_next = PH_HIGH;
          end
          res_valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = rx_byte;
        end
        default: begin
          header_high_next = rx_byte;
          phase_next       = PH_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HIGH;
      header_high   <= '0;
      bytes_left    <= '0;
      length_so_far <= '0;
      sticky_error  <= ERR_NONE;
    end else if (take) begin
      phase         <= phase_next;
      header_high   <= header_high_next;
      bytes_left    <= bytes_left_next;
      length_so_far <= length_so_far_next;
      sticky_error  <= sticky_error_next;
    end
  end

endmodule

[src/cmd_obuf.sv]
module cmd_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cmd_pkg::result_t din,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output cmd_pkg::result_t dout
);
  import cmd_pkg::*;

  result_t held;

  // a new result may enter when the register is empty or drains this cycle
  assign room      = !out_valid || out_ready;
  assign dout      = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= din;
    end
  end

endmodule

[src/chunked_message_deframer_unit.sv]
// Chunk deframer: takes one received byte per transfer on the slave side and strips the
// 2-byte big-endian chunk headers, passing payload bytes on; a zero header ends the message
// and yields an end-of-message result with the total payload length, and a link fault or a
// message past 2^24-1 bytes gives a sticky error result for every later transfer until
// reset. Each taken byte's result is loaded into the output register at the accepting edge,
// so it shows on the master side in the next cycle; header bytes give no output unless they
// end the message or hit an error. While a result waits there and the master side is not
// ready, the slave side is held off, header bytes included; a new byte enters in the cycle
// the result drains, so throughput is one byte per cycle while the master side keeps up.
module chunked_message_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // link_fault
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [cmd_pkg::OUT_DATA_W-1:0] m_axis_tdata, // data_byte, message_length, error_code
  output logic [1:0]  m_axis_tuser    // kind
);
  import cmd_pkg::*;

  logic    take;
  logic    res_valid;
  logic    room;
  result_t res;
  result_t out_res;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  cmd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .rx_byte    (s_axis_tdata),
    .link_fault (s_axis_tuser),
    .res_valid  (res_valid),
    .res        (res)
  );

  cmd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .din       (res),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {
    (OUT_DATA_W - MSG_LEN_W - 10)'(0),
    out_res.error_code,
    out_res.message_length,
    out_res.data_byte
  };

endmodule
